/* rtl/fletcher_framed_packet_receiver_macros.svh */
// Assertion macros for the Fletcher framed packet receiver checker.
`ifndef FLETCHER_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define FLETCHER_FRAMED_PACKET_RECEIVER_MACROS_SVH

// Clocked property, disabled while reset is high.
`define FPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define FPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/fpr_pkg.sv */
// Types and constants shared by the Fletcher framed packet receiver files.
package fpr_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_SYNC_VALUE = 2'd0;
   localparam csr_index_type CSR_MIN_LENGTH = 2'd1;
   localparam csr_index_type CSR_MAX_LENGTH = 2'd2;

   localparam byte_type SYNC_VALUE_RESET = 8'h0A;
   localparam byte_type MIN_LENGTH_RESET = 8'd8;
   localparam byte_type MAX_LENGTH_RESET = 8'd24;
   localparam byte_type HEADER_BYTES     = 8'd8;
   localparam byte_type MOD_BASE         = 8'd255;

   localparam int RSP_DATA_WIDTH = 48;

   typedef enum logic [7:0] {
      PH_SYNC  = 8'b0000_0001,
      PH_LEN   = 8'b0000_0010,
      PH_CLO   = 8'b0000_0100,
      PH_CHI   = 8'b0000_1000,
      PH_ACK   = 8'b0001_0000,
      PH_CLASS = 8'b0010_0000,
      PH_SUB   = 8'b0100_0000,
      PH_DATA  = 8'b1000_0000
   } phase_type;

endpackage

/* rtl/fletcher_framed_packet_receiver.sv */
// Fletcher framed packet receiver: takes serial bytes one transfer per cycle, hunts for
// the sync byte, checks the length against the csr bounds, captures the check pair and
// header, runs Fletcher-16 sums (mod 255) from the ack byte to the end and compares the
// computed pair on the last byte. Every accepted byte gives exactly one result in the
// next cycle through a single output register; a new byte is taken every cycle while
// that register is empty or being drained, so sustained rate is one byte per clock.
// rsp_tlast marks the byte that ends a frame, rsp_tuser marks payload bytes.
// The csr port is always ready and should be written only while no byte is in flight.
module fletcher_framed_packet_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  fpr_pkg::byte_type             req_tdata,   // [7:0] rx_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] check_ok, [8:1] frame_length, [9] ack_requested, [17:10] class_code,
   // [25:18] sub_code, [33:26] payload_index, [41:34] payload_byte, [47:42] zero
   output logic [fpr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                          rsp_tlast,   // frame_done
   output logic                          rsp_tuser,   // [0] payload_valid
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  fpr_pkg::csr_index_type        csr_index,
   input  fpr_pkg::byte_type             csr_data
);
   import fpr_pkg::*;

   function automatic byte_type add_mod255(input byte_type a, input byte_type b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MOD_BASE}) begin
         s = s - {1'b0, MOD_BASE};
      end
      return s[7:0];
   endfunction

   byte_type  sync_value_ff, min_length_ff, max_length_ff;
   phase_type phase_ff, phase_in;
   byte_type  byte_count_ff, byte_count_in;
   byte_type  length_ff, length_in;
   byte_type  check_low_ff, check_low_in;
   byte_type  check_high_ff, check_high_in;
   byte_type  ack_ff, ack_in;
   byte_type  class_ff, class_in;
   byte_type  sub_ff, sub_in;
   byte_type  sum_first_ff, sum_first_in;
   byte_type  sum_second_ff, sum_second_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_user_ff, rsp_user_in;

   logic      req_xfer;
   byte_type  rx;
   byte_type  first_base, second_base, first_add, second_add;
   byte_type  count_inc, calc_low, calc_high;
   logic      done, ok, pvalid;
   byte_type  pindex, pbyte;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign rx         = req_tdata;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // running sums restart at the ack byte
   assign first_base  = (phase_ff == PH_ACK) ? '0 : sum_first_ff;
   assign second_base = (phase_ff == PH_ACK) ? '0 : sum_second_ff;
   assign first_add   = add_mod255(first_base, rx);
   assign second_add  = add_mod255(second_base, first_add);
   assign calc_low    = MOD_BASE - add_mod255(first_add, second_add);
   assign calc_high   = MOD_BASE - add_mod255(calc_low, first_add);
   assign count_inc   = (byte_count_ff != MOD_BASE) ? byte_count_ff + 8'd1 : byte_count_ff;

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      length_in     = length_ff;
      check_low_in  = check_low_ff;
      check_high_in = check_high_ff;
      ack_in        = ack_ff;
      class_in      = class_ff;
      sub_in        = sub_ff;
      sum_first_in  = sum_first_ff;
      sum_second_in = sum_second_ff;
      done          = 1'b0;
      ok            = 1'b0;
      pvalid        = 1'b0;
      pindex        = '0;
      pbyte         = '0;
      case (phase_ff)
         PH_SYNC: begin
            if (rx == sync_value_ff) begin
               phase_in      = PH_LEN;
               byte_count_in = 8'd1;
            end else begin
               byte_count_in = 8'd0;
            end
         end
         PH_LEN: begin
            if (rx >= min_length_ff && rx <= max_length_ff) begin
               length_in     = rx;
               byte_count_in = 8'd2;
               phase_in      = PH_CLO;
            end else begin
               byte_count_in = 8'd0;
               phase_in      = PH_SYNC;
            end
         end
         PH_CLO: begin
            check_low_in  = rx;
            byte_count_in = 8'd3;
            phase_in      = PH_CHI;
         end
         PH_CHI: begin
            check_high_in = rx;
            byte_count_in = 8'd4;
            phase_in      = PH_ACK;
         end
         PH_ACK: begin
            ack_in        = rx;
            sum_first_in  = first_add;
            sum_second_in = second_add;
            byte_count_in = 8'd5;
            phase_in      = PH_CLASS;
         end
         PH_CLASS: begin
            class_in      = rx;
            sum_first_in  = first_add;
            sum_second_in = second_add;
            byte_count_in = 8'd6;
            phase_in      = PH_SUB;
         end
         PH_SUB: begin
            sub_in        = rx;
            sum_first_in  = first_add;
            sum_second_in = second_add;
            byte_count_in = 8'd7;
            phase_in      = PH_DATA;
         end
         PH_DATA: begin
            sum_first_in  = first_add;
            sum_second_in = second_add;
            byte_count_in = count_inc;
            pvalid        = 1'b1;
            pindex        = (count_inc >= HEADER_BYTES) ? count_inc - HEADER_BYTES : '0;
            pbyte         = rx;
            if (count_inc >= length_ff) begin
               done          = 1'b1;
               ok            = (calc_low == check_low_ff) && (calc_high == check_high_ff);
               phase_in      = PH_SYNC;
               byte_count_in = 8'd0;
            end
         end
         default: begin
            phase_in      = PH_SYNC;
            byte_count_in = 8'd0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, pbyte, pindex, sub_in, class_in, ack_in[0], length_in, ok};
         rsp_last_in  = done;
         rsp_user_in  = pvalid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff <= SYNC_VALUE_RESET;
         min_length_ff <= MIN_LENGTH_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_VALUE: sync_value_ff <= csr_data;
            CSR_MIN_LENGTH: min_length_ff <= csr_data;
            CSR_MAX_LENGTH: max_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC;
         byte_count_ff <= '0;
         length_ff     <= '0;
         check_low_ff  <= '0;
         check_high_ff <= '0;
         ack_ff        <= '0;
         class_ff      <= '0;
         sub_ff        <= '0;
         sum_first_ff  <= '0;
         sum_second_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer) begin
            phase_ff      <= phase_in;
            byte_count_ff <= byte_count_in;
            length_ff     <= length_in;
            check_low_ff  <= check_low_in;
            check_high_ff <= check_high_in;
            ack_ff        <= ack_in;
            class_ff      <= class_in;
            sub_ff        <= sub_in;
            sum_first_ff  <= sum_first_in;
            sum_second_ff <= sum_second_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

/* rtl/fpr_checker.sv */
// Port-level checker for the Fletcher framed packet receiver, bound to the top level.
`include "fletcher_framed_packet_receiver_macros.svh"

module fpr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [fpr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input logic                                rsp_tlast,
   input logic                                rsp_tuser
);
   import fpr_pkg::*;

   `FPR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")
   `FPR_ASSERT(a_req_gives_rsp, clock, reset, req_tvalid && req_tready |=> rsp_tvalid, "accepted byte gave no result")
   `FPR_ASSERT(a_done_on_payload, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tuser, "frame ended on a non-payload byte")
   `FPR_ASSERT(a_ok_only_done, clock, reset, rsp_tvalid && !rsp_tlast |-> !rsp_tdata[0], "check_ok set without frame end")
   `FPR_ASSERT(a_payload_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[41:26] == '0, "payload fields set on header byte")

endmodule

bind fletcher_framed_packet_receiver fpr_checker u_fpr_checker (.*);

/* tb/fletcher_framed_packet_receiver_tb.sv */
// Self-checking testbench for the Fletcher-16 framed packet receiver.
`timescale 1ns / 1ps

module fletcher_framed_packet_receiver_tb;
   import fpr_pkg::*;

   localparam int HOLD_CYCLES = 200;
   localparam int STALL_LIMIT = 4000;
   localparam int DIRECTED_ROWS = 23;
   localparam int PHASES = 6;

   typedef struct packed {
      logic       frame_done;
      logic       check_ok;
      logic [7:0] frame_length;
      logic       ack_requested;
      logic [7:0] class_code;
      logic [7:0] sub_code;
      logic       payload_valid;
      logic [7:0] payload_index;
      logic [7:0] payload_byte;
   } rx_result_type;

   typedef struct {
      byte_type      rx;
      bit            typed;
      rx_result_type want;
   } stim_row_type;

   typedef struct {
      byte_type sync_byte;
      byte_type len_lo;
      byte_type len_hi;
      int       bytes;
      bit       long_frame;
   } csr_phase_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   byte_type                  req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index = CSR_SYNC_VALUE;
   byte_type                  csr_data = '0;

   // predictor copy of configuration and parse state
   byte_type   cfg_sync = SYNC_VALUE_RESET;
   byte_type   cfg_min = MIN_LENGTH_RESET;
   byte_type   cfg_max = MAX_LENGTH_RESET;
   phase_type  rx_phase = PH_SYNC;
   byte_type   rx_count = '0;
   byte_type   len_reg = '0;
   byte_type   chk_lo_rx = '0;
   byte_type   chk_hi_rx = '0;
   byte_type   ack_reg = '0;
   byte_type   class_reg = '0;
   byte_type   sub_reg = '0;
   byte_type   sum_a = '0;
   byte_type   sum_b = '0;

   rx_result_type predicted_rx_results [$];
   int         error_count = 0;
   int         rx_sent = 0;
   int         req_calm = 0;
   int         rsp_calm = 0;
   int         rsp_stall_left = 0;
   bit         rsp_hold_req = 1'b0;
   int         idle_cycles = 0;

   // defaults: sync 0x0A, length 8..24
   stim_row_type directed_table [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, '0},
      '{8'hFF, 1'b1, '0},
      '{8'h0A, 1'b1, '0},
      '{8'h07, 1'b1, '0},
      '{8'h0A, 1'b1, '0},
      '{8'h19, 1'b1, '0},
      '{8'h0A, 1'b1, '0},
      '{8'h08, 1'b1, '{1'b0, 1'b0, 8'd8, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0}},
      '{8'hFA, 1'b0, '0},
      '{8'h04, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h0A, 1'b0, '0},
      '{8'h09, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0}
   };

   csr_phase_type phase_plan [PHASES] = '{
      '{SYNC_VALUE_RESET, MIN_LENGTH_RESET, MAX_LENGTH_RESET, 80, 1'b0},
      '{8'hFF, 8'd8,   8'd255, 70,  1'b1},
      '{8'h00, 8'd0,   8'd12,  100, 1'b0},
      '{8'h5A, 8'd20,  8'd10,  40,  1'b0},
      '{8'hA5, 8'd255, 8'd255, 200, 1'b0},
      '{8'h0A, 8'd12,  8'd16,  80,  1'b0}
   };

   fletcher_framed_packet_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void fletcher_fold(inout byte_type a, inout byte_type s,
                                         input byte_type b);
      a = byte_type'((int'(a) + int'(b)) % 255);
      s = byte_type'((int'(s) + int'(a)) % 255);
   endfunction

   // returns {high, low}
   function automatic logic [15:0] fletcher_pair(input byte_type a, input byte_type s);
      byte_type lo, hi;
      lo = byte_type'(255 - ((int'(a) + int'(s)) % 255));
      hi = byte_type'(255 - ((int'(lo) + int'(a)) % 255));
      return {hi, lo};
   endfunction

   function automatic rx_result_type parse_rx_byte(input byte_type b);
      rx_result_type r;
      r = '0;
      case (rx_phase)
         PH_SYNC: begin
            if (b == cfg_sync) begin
               rx_phase = PH_LEN;
               rx_count = 8'd1;
            end else begin
               rx_count = 8'd0;
            end
         end
         PH_LEN: begin
            if (b >= cfg_min && b <= cfg_max) begin
               len_reg = b;
               rx_count = 8'd2;
               rx_phase = PH_CLO;
            end else begin
               rx_count = 8'd0;
               rx_phase = PH_SYNC;
            end
         end
         PH_CLO: begin
            chk_lo_rx = b;
            rx_count = 8'd3;
            rx_phase = PH_CHI;
         end
         PH_CHI: begin
            chk_hi_rx = b;
            rx_count = 8'd4;
            rx_phase = PH_ACK;
         end
         PH_ACK: begin
            ack_reg = b;
            sum_a = '0;
            sum_b = '0;
            fletcher_fold(sum_a, sum_b, b);
            rx_count = 8'd5;
            rx_phase = PH_CLASS;
         end
         PH_CLASS: begin
            class_reg = b;
            fletcher_fold(sum_a, sum_b, b);
            rx_count = 8'd6;
            rx_phase = PH_SUB;
         end
         PH_SUB: begin
            sub_reg = b;
            fletcher_fold(sum_a, sum_b, b);
            rx_count = 8'd7;
            rx_phase = PH_DATA;
         end
         default: begin
            fletcher_fold(sum_a, sum_b, b);
            if (rx_count < 8'd255) rx_count = rx_count + 8'd1;
            r.payload_valid = 1'b1;
            r.payload_index = (rx_count >= HEADER_BYTES) ? rx_count - HEADER_BYTES : 8'd0;
            r.payload_byte = b;
            if (rx_count >= len_reg) begin
               r.frame_done = 1'b1;
               r.check_ok = (fletcher_pair(sum_a, sum_b) == {chk_hi_rx, chk_lo_rx});
               rx_phase = PH_SYNC;
               rx_count = 8'd0;
            end
         end
      endcase
      r.frame_length = len_reg;
      r.ack_requested = ack_reg[0];
      r.class_code = class_reg;
      r.sub_code = sub_reg;
      return r;
   endfunction

   function automatic int pick_pause(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 4) begin
         calm_left = $urandom_range(60, 20);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic void match_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_rx_byte(input byte_type b, input bit typed, input rx_result_type want);
      int gap;
      rx_result_type r;
      gap = (rsp_stall_left > 0) ? 0 : pick_pause(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = parse_rx_byte(b);
      predicted_rx_results.push_back(typed ? want : r);
      rx_sent++;
   endtask

   task automatic send_frames(input int byte_target, input bit want_long);
      byte_type    body [$];
      byte_type    len, fa, fb, junk;
      logic [15:0] pair;
      int          start, pick, span, total, cut, i;
      start = rx_sent;
      while (rx_sent - start < byte_target) begin
         pick = $urandom_range(99);
         if (cfg_min <= cfg_max && pick < 80) begin
            span = int'(cfg_max) - int'(cfg_min);
            if (span > 20) span = 20;
            len = cfg_min + byte_type'($urandom_range(span));
            if (want_long && $urandom_range(3) == 0) begin
               len = cfg_max;
               want_long = 1'b0;
            end
            total = (len < HEADER_BYTES) ? int'(HEADER_BYTES) : int'(len);
            fa = '0;
            fb = '0;
            body.delete();
            repeat (total - 4) begin
               junk = byte_type'($urandom_range(255));
               body.push_back(junk);
               fletcher_fold(fa, fb, junk);
            end
            pair = fletcher_pair(fa, fb);
            if ($urandom_range(3) == 0) pair = 16'($urandom_range(16'hFFFF));
            // a few frames are cut short and run into what follows
            cut = (pick >= 72) ? $urandom_range(body.size() - 1) : body.size();
            send_rx_byte(cfg_sync, 1'b0, '0);
            send_rx_byte(len, 1'b0, '0);
            send_rx_byte(pair[7:0], 1'b0, '0);
            send_rx_byte(pair[15:8], 1'b0, '0);
            for (i = 0; i < cut; i++) send_rx_byte(body[i], 1'b0, '0);
         end else if (pick < 90) begin
            // sync followed by a random or sync-valued length byte
            send_rx_byte(cfg_sync, 1'b0, '0);
            junk = $urandom_range(1) ? cfg_sync : byte_type'($urandom_range(255));
            send_rx_byte(junk, 1'b0, '0);
         end else begin
            repeat ($urandom_range(8, 1)) begin
               send_rx_byte(byte_type'($urandom_range(255)), 1'b0, '0);
            end
         end
      end
   endtask

   task automatic wait_rx_drained();
      req_tvalid <= 1'b0;
      while (predicted_rx_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_csrs(input csr_phase_type ph);
      csr_index_type idx [3];
      byte_type      val [3];
      int            i;
      idx = '{CSR_SYNC_VALUE, CSR_MIN_LENGTH, CSR_MAX_LENGTH};
      val = '{ph.sync_byte, ph.len_lo, ph.len_hi};
      for (i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[i])
            CSR_SYNC_VALUE: cfg_sync = val[i];
            CSR_MIN_LENGTH: cfg_min = val[i];
            default:        cfg_max = val[i];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic take_rx_result();
      rx_result_type want, got;
      got.frame_done    = rsp_tlast;
      got.check_ok      = rsp_tdata[0];
      got.frame_length  = rsp_tdata[8:1];
      got.ack_requested = rsp_tdata[9];
      got.class_code    = rsp_tdata[17:10];
      got.sub_code      = rsp_tdata[25:18];
      got.payload_valid = rsp_tuser;
      got.payload_index = rsp_tdata[33:26];
      got.payload_byte  = rsp_tdata[41:34];
      if (predicted_rx_results.size() == 0) begin
         $error("result transfer with no byte outstanding");
         error_count++;
      end else begin
         want = predicted_rx_results.pop_front();
         match_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
         match_field("check_ok", 8'(want.check_ok), 8'(got.check_ok));
         match_field("frame_length", want.frame_length, got.frame_length);
         match_field("ack_requested", 8'(want.ack_requested), 8'(got.ack_requested));
         match_field("class_code", want.class_code, got.class_code);
         match_field("sub_code", want.sub_code, got.sub_code);
         match_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
         match_field("payload_index", want.payload_index, got.payload_index);
         match_field("payload_byte", want.payload_byte, got.payload_byte);
      end
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) take_rx_result();
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_stall_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall_left = pick_pause(rsp_calm);
         end
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int i, p;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_rx_byte(directed_table[i].rx, directed_table[i].typed, directed_table[i].want);
      end
      rsp_hold_req = 1'b1;
      for (p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            wait_rx_drained();
            program_csrs(phase_plan[p]);
         end
         send_frames(phase_plan[p].bytes, phase_plan[p].long_frame);
      end
      wait_rx_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
